[rtl/servo_bus_packet_receiver_top_defines.svh]
// assertion macros for the servo bus packet receiver
// expects clk and arst_n in the scope where a macro is used
`ifndef SERVO_BUS_PACKET_RECEIVER_TOP_DEFINES_SVH
`define SERVO_BUS_PACKET_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define SBPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SBPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sbpr_pkg.sv]
// shared types and constants of the servo bus packet receiver
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package sbpr_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [15:0] tick_t;

	// item operation codes
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// result kinds
	typedef enum logic {
		KIND_PARAM = 1'b0,
		KIND_END   = 1'b1
	} kind_t;

	// packet end status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_BADLEN   = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic {
		REG_DEVICE_ID = 1'b0,
		REG_TIMEOUT   = 1'b1
	} reg_idx_t;

	localparam byte_t HEADER_BYTE  = 8'hFF;
	localparam byte_t BROADCAST_ID = 8'hFE;
	localparam byte_t MIN_LENGTH   = 8'd2;
	localparam tick_t TICK_MAX     = 16'hFFFF;

	localparam byte_t DEVICE_ID_RESET = 8'd1;
	localparam tick_t TIMEOUT_RESET   = 16'd1000;

	localparam int CFG_DATA_W = 16;

endpackage

[rtl/sbpr_channels.sv]
// valid/ready channel interfaces for the servo bus packet receiver
// depends on sbpr_pkg
`timescale 1ns / 1ps

// received byte or time tick
interface sbpr_item_if;
	logic            valid;
	logic            ready;
	sbpr_pkg::op_t   operation;
	sbpr_pkg::byte_t rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// parameter byte or packet end report
interface sbpr_result_if;
	logic              valid;
	logic              ready;
	sbpr_pkg::kind_t   result_kind;
	sbpr_pkg::byte_t   packet_id;
	sbpr_pkg::byte_t   instruction;
	sbpr_pkg::byte_t   packet_length;
	sbpr_pkg::byte_t   param_index;
	sbpr_pkg::byte_t   param_byte;
	sbpr_pkg::status_t status;
	logic              last;

	modport source (
		output valid, output result_kind, output packet_id, output instruction,
		output packet_length, output param_index, output param_byte,
		output status, output last, input ready
	);
	modport sink (
		input valid, input result_kind, input packet_id, input instruction,
		input packet_length, input param_index, input param_byte,
		input status, input last, output ready
	);
endinterface

[rtl/servo_bus_packet_receiver_top.sv]
// servo bus packet receiver: header hunt, id filter, parameter output, checksum check
// depends on sbpr_pkg, sbpr_channels.sv and servo_bus_packet_receiver_top_defines.svh
`timescale 1ns / 1ps
`include "servo_bus_packet_receiver_top_defines.svh"

// Takes one request per cycle on item: either a received byte or one time tick.
// Each accepted request is handled by the frame state machine; its result, if any, sits in
// the result register and is offered on result from the next cycle. item.ready
// is high whenever the result register is empty or is being taken in the same
// cycle, so a stalled sink stops the stream only while a result waits. The
// frame state machine hunts for two 0xFF bytes, keeps packets addressed to
// device_id or broadcast 0xFE, emits each parameter byte with its index and
// ends with one report: ok, checksum error (inverted 8-bit sum of id, length,
// instruction and parameters), timeout (ticks counted after the length byte
// reach timeout_ticks) or bad length (below two). Configuration writes through
// wr_en / wr_index / wr_data take effect at the next cycle and are meant for
// idle periods only; index 0 is device_id (reset 1), index 1 timeout_ticks
// (reset 1000).
module servo_bus_packet_receiver_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  sbpr_pkg::reg_idx_t                  wr_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]     wr_data,
	sbpr_item_if.sink                           item,
	sbpr_result_if.source                       result
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ID,
		PH_LEN,
		PH_INSTR,
		PH_PARAM,
		PH_CHECK
	} phase_t;

	// configuration
	sbpr_pkg::byte_t device_id_q;
	sbpr_pkg::tick_t timeout_q;

	// frame state
	phase_t          phase_q, phase_d;
	logic            marker_q, marker_d;
	sbpr_pkg::byte_t id_q, id_d;
	sbpr_pkg::byte_t len_q, len_d;
	sbpr_pkg::byte_t instr_q, instr_d;
	sbpr_pkg::byte_t sum_q, sum_d;
	sbpr_pkg::byte_t count_q, count_d;
	sbpr_pkg::tick_t ticks_q, ticks_d;

	// result register
	logic              res_valid_q;
	sbpr_pkg::kind_t   res_kind_q, res_kind_d;
	sbpr_pkg::byte_t   res_id_q;
	sbpr_pkg::byte_t   res_instr_q;
	sbpr_pkg::byte_t   res_len_q;
	sbpr_pkg::byte_t   res_index_q, res_index_d;
	sbpr_pkg::byte_t   res_byte_q, res_byte_d;
	sbpr_pkg::status_t res_status_q, res_status_d;

	logic            emit;
	logic            take;
	sbpr_pkg::byte_t b;
	sbpr_pkg::tick_t tick_inc;

	// accept whenever the result slot is free or drains this cycle
	assign item.ready = !res_valid_q || result.ready;
	assign take       = item.valid && item.ready;
	assign b          = item.rx_byte;
	assign tick_inc   = (ticks_q != sbpr_pkg::TICK_MAX) ? ticks_q + 16'd1 : ticks_q;

	always_comb begin
		phase_d      = phase_q;
		marker_d     = marker_q;
		id_d         = id_q;
		len_d        = len_q;
		instr_d      = instr_q;
		sum_d        = sum_q;
		count_d      = count_q;
		ticks_d      = ticks_q;
		emit         = 1'b0;
		res_kind_d   = sbpr_pkg::KIND_END;
		res_index_d  = 8'd0;
		res_byte_d   = 8'd0;
		res_status_d = sbpr_pkg::ST_OK;

		if (item.operation == sbpr_pkg::OP_TICK) begin
			// ticks only count once the length byte is in
			if (phase_q == PH_INSTR || phase_q == PH_PARAM || phase_q == PH_CHECK) begin
				ticks_d = tick_inc;
				if (tick_inc >= timeout_q) begin
					emit         = 1'b1;
					res_status_d = sbpr_pkg::ST_TIMEOUT;
					phase_d      = PH_HUNT;
					marker_d     = 1'b0;
				end
			end
		end else begin
			case (phase_q)
				PH_ID: begin
					id_d    = b;
					len_d   = 8'd0;
					instr_d = 8'd0;
					count_d = 8'd0;
					ticks_d = 16'd0;
					sum_d   = b;
					if (b == device_id_q || b == sbpr_pkg::BROADCAST_ID) begin
						phase_d = PH_LEN;
					end else begin
						// foreign id: drop silently
						phase_d  = PH_HUNT;
						marker_d = 1'b0;
					end
				end
				PH_LEN: begin
					len_d   = b;
					sum_d   = sum_q + b;
					ticks_d = 16'd0;
					if (b < sbpr_pkg::MIN_LENGTH) begin
						emit         = 1'b1;
						res_status_d = sbpr_pkg::ST_BADLEN;
						phase_d      = PH_HUNT;
						marker_d     = 1'b0;
					end else begin
						phase_d = PH_INSTR;
					end
				end
				PH_INSTR: begin
					instr_d = b;
					sum_d   = sum_q + b;
					count_d = 8'd0;
					phase_d = (len_q == sbpr_pkg::MIN_LENGTH) ? PH_CHECK : PH_PARAM;
				end
				PH_PARAM: begin
					emit        = 1'b1;
					res_kind_d  = sbpr_pkg::KIND_PARAM;
					res_index_d = count_q;
					res_byte_d  = b;
					sum_d       = sum_q + b;
					count_d     = count_q + 8'd1;
					if ((9'(count_q) + 9'd1 + 9'(sbpr_pkg::MIN_LENGTH)) >= 9'(len_q)) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					emit         = 1'b1;
					res_status_d = (b == ~sum_q) ? sbpr_pkg::ST_OK : sbpr_pkg::ST_CHECKSUM;
					phase_d      = PH_HUNT;
					marker_d     = 1'b0;
				end
				default: begin
					// header hunt: two header bytes in a row
					if (b == sbpr_pkg::HEADER_BYTE) begin
						if (marker_q) begin
							marker_d = 1'b0;
							phase_d  = PH_ID;
						end else begin
							marker_d = 1'b1;
						end
					end else begin
						marker_d = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q  <= sbpr_pkg::DEVICE_ID_RESET;
			timeout_q    <= sbpr_pkg::TIMEOUT_RESET;
			phase_q      <= PH_HUNT;
			marker_q     <= 1'b0;
			id_q         <= 8'd0;
			len_q        <= 8'd0;
			instr_q      <= 8'd0;
			sum_q        <= 8'd0;
			count_q      <= 8'd0;
			ticks_q      <= 16'd0;
			res_valid_q  <= 1'b0;
			res_kind_q   <= sbpr_pkg::KIND_PARAM;
			res_id_q     <= 8'd0;
			res_instr_q  <= 8'd0;
			res_len_q    <= 8'd0;
			res_index_q  <= 8'd0;
			res_byte_q   <= 8'd0;
			res_status_q <= sbpr_pkg::ST_OK;
		end else begin
			if (wr_en) begin
				case (wr_index)
					sbpr_pkg::REG_DEVICE_ID: device_id_q <= wr_data[7:0];
					sbpr_pkg::REG_TIMEOUT:   timeout_q   <= wr_data[15:0];
					default: ;
				endcase
			end

			if (take) begin
				phase_q  <= phase_d;
				marker_q <= marker_d;
				id_q     <= id_d;
				len_q    <= len_d;
				instr_q  <= instr_d;
				sum_q    <= sum_d;
				count_q  <= count_d;
				ticks_q  <= ticks_d;
			end

			// result slot: load on emit, else drain when taken
			if (take && emit) begin
				res_valid_q  <= 1'b1;
				res_kind_q   <= res_kind_d;
				res_id_q     <= id_d;
				res_instr_q  <= instr_d;
				res_len_q    <= len_d;
				res_index_q  <= res_index_d;
				res_byte_q   <= res_byte_d;
				res_status_q <= res_status_d;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.result_kind   = res_kind_q;
	assign result.packet_id     = res_id_q;
	assign result.instruction   = res_instr_q;
	assign result.packet_length = res_len_q;
	assign result.param_index   = res_index_q;
	assign result.param_byte    = res_byte_q;
	assign result.status        = res_status_q;
	assign result.last          = (res_kind_q == sbpr_pkg::KIND_END);

	// parameter results carry ok status and sit inside the declared length
	`SBPR_ASSERT_NOW(a_param_shape, result.valid && result.result_kind == sbpr_pkg::KIND_PARAM, result.status == sbpr_pkg::ST_OK && (9'(result.param_index) + 9'(sbpr_pkg::MIN_LENGTH)) < 9'(result.packet_length), "parameter result out of shape")
	// a checksum byte always closes the packet with a report
	`SBPR_ASSERT_NEXT(a_check_ends, take && item.operation == sbpr_pkg::OP_BYTE && phase_q == PH_CHECK, phase_q == PH_HUNT && result.valid && result.last, "checksum byte did not end packet")
	// a bad length report always holds a length below two
	`SBPR_ASSERT_NOW(a_badlen_len, result.valid && result.last && result.status == sbpr_pkg::ST_BADLEN, result.packet_length < sbpr_pkg::MIN_LENGTH, "bad length report with legal length")

endmodule

[tb/tb.sv]
// self-checking bench for the servo bus packet receiver: random framed byte streams
// with ticks, checked field by field against a cycle-free frame predictor
// depends on sbpr_pkg, sbpr_channels.sv and servo_bus_packet_receiver_top
`timescale 1ns / 1ps

module tb;
	import sbpr_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 10;
	// settle time through the frame logic and the result register, with margin
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS   = 80;

	// where the predictor stands within a frame
	typedef enum logic [2:0] {
		FR_HUNT,
		FR_ID,
		FR_LEN,
		FR_INSTR,
		FR_PARAM,
		FR_CHECK
	} frame_phase_t;

	// one request on the item channel
	typedef struct {
		op_t   op;
		byte_t data;
	} rx_item_t;

	// one predicted result
	typedef struct {
		kind_t   kind;
		byte_t   id;
		byte_t   instr;
		byte_t   len;
		byte_t   idx;
		byte_t   val;
		status_t st;
		logic    last;
	} report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	reg_idx_t              wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	sbpr_item_if   item_ch ();
	sbpr_result_if result_ch ();

	servo_bus_packet_receiver_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	// requests still to be sent, results still owed by the block
	rx_item_t rx_stream[$];
	report_t  due_reports[$];
	rx_item_t cur_item;
	report_t  due_head;
	int       fail_count;

	// idling control for both sides
	bit src_idle;
	bit sink_idle;
	int send_hold;
	int take_hold;

	// predictor copy of the registers
	byte_t own_id;
	tick_t tick_limit;

	// predictor copy of the frame state
	frame_phase_t fr_phase;
	bit           saw_ff;
	byte_t        pk_id;
	byte_t        pk_len;
	byte_t        pk_instr;
	byte_t        pk_sum;
	byte_t        pk_count;
	tick_t        pk_ticks;

	always #HALF_PERIOD clk = ~clk;

	// mostly no gap, sometimes a short one, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------------
	// frame predictor
	// ---------------------------------------------------------------------

	function automatic void emit_report(kind_t kind, byte_t idx, byte_t val, status_t st);
		report_t r;
		r.kind  = kind;
		r.id    = pk_id;
		r.instr = pk_instr;
		r.len   = pk_len;
		r.idx   = idx;
		r.val   = val;
		r.st    = st;
		r.last  = (kind == KIND_END);
		due_reports.push_back(r);
	endfunction

	// end report, then back to header hunting with the first-marker flag cleared
	function automatic void close_packet(status_t st);
		emit_report(KIND_END, 8'd0, 8'd0, st);
		fr_phase = FR_HUNT;
		saw_ff   = 1'b0;
	endfunction

	function automatic void deframe_step(op_t op, byte_t b);
		if (op == OP_TICK) begin
			// ticks only count once the length byte is in
			if (fr_phase == FR_INSTR || fr_phase == FR_PARAM || fr_phase == FR_CHECK) begin
				if (pk_ticks != TICK_MAX)
					pk_ticks++;
				if (pk_ticks >= tick_limit)
					close_packet(ST_TIMEOUT);
			end
		end else begin
			case (fr_phase)
				FR_ID: begin
					pk_id    = b;
					pk_len   = 8'd0;
					pk_instr = 8'd0;
					pk_count = 8'd0;
					pk_ticks = 16'd0;
					pk_sum   = b;
					if (b == own_id || b == BROADCAST_ID) begin
						fr_phase = FR_LEN;
					end else begin
						// foreign id, silent drop
						fr_phase = FR_HUNT;
						saw_ff   = 1'b0;
					end
				end
				FR_LEN: begin
					pk_len   = b;
					pk_sum   = pk_sum + b;
					pk_ticks = 16'd0;
					if (b < MIN_LENGTH)
						close_packet(ST_BADLEN);
					else
						fr_phase = FR_INSTR;
				end
				FR_INSTR: begin
					pk_instr = b;
					pk_sum   = pk_sum + b;
					pk_count = 8'd0;
					fr_phase = (pk_len == MIN_LENGTH) ? FR_CHECK : FR_PARAM;
				end
				FR_PARAM: begin
					emit_report(KIND_PARAM, pk_count, b, ST_OK);
					pk_sum   = pk_sum + b;
					pk_count = pk_count + 8'd1;
					if (int'(pk_count) + int'(MIN_LENGTH) >= int'(pk_len))
						fr_phase = FR_CHECK;
				end
				FR_CHECK: begin
					close_packet((b == byte_t'(~pk_sum)) ? ST_OK : ST_CHECKSUM);
				end
				default: begin
					// two header bytes in a row open a frame
					if (b == HEADER_BYTE) begin
						if (saw_ff) begin
							saw_ff   = 1'b0;
							fr_phase = FR_ID;
						end else begin
							saw_ff = 1'b1;
						end
					end else begin
						saw_ff = 1'b0;
					end
				end
			endcase
		end
	endfunction

	// ---------------------------------------------------------------------
	// driver: one request per handshake, random gaps between them
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			// the request that leaves now is the one the predictor sees
			if (item_ch.valid && item_ch.ready)
				deframe_step(item_ch.operation, item_ch.rx_byte);
			if (!item_ch.valid || item_ch.ready) begin
				if (send_hold > 0) begin
					send_hold--;
					item_ch.valid <= 1'b0;
				end else if (rx_stream.size() > 0) begin
					cur_item = rx_stream.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.operation <= cur_item.op;
					item_ch.rx_byte   <= cur_item.data;
					if (src_idle)
						send_hold = idle_gap();
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor: compare each taken result with the oldest prediction
	// ---------------------------------------------------------------------

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_reports.size() == 0) begin
					$error("result taken with no prediction pending");
					fail_count++;
				end else begin
					due_head = due_reports.pop_front();
					check_field("result_kind", due_head.kind, result_ch.result_kind);
					check_field("packet_id", due_head.id, result_ch.packet_id);
					check_field("instruction", due_head.instr, result_ch.instruction);
					check_field("packet_length", due_head.len, result_ch.packet_length);
					check_field("param_index", due_head.idx, result_ch.param_index);
					check_field("param_byte", due_head.val, result_ch.param_byte);
					check_field("status", due_head.st, result_ch.status);
					check_field("last", due_head.last, result_ch.last);
				end
			end
			// back-pressure: stalls start at random while ready is up
			if (take_hold > 0) begin
				take_hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (sink_idle && result_ch.ready && $urandom_range(3) == 0)
					take_hold = idle_gap();
			end
		end
	end

	// ---------------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------------

	function automatic void push_byte(byte_t b);
		rx_stream.push_back('{OP_BYTE, b});
	endfunction

	// tick with a random payload byte, which the block must ignore
	function automatic void maybe_tick(int tick_pct);
		if ($urandom_range(99) < tick_pct)
			rx_stream.push_back('{OP_TICK, byte_t'($urandom())});
	endfunction

	// full frame: header, id, length, instruction, parameters, checksum;
	// a cut frame stops somewhere in its body
	function automatic void queue_packet(byte_t id, byte_t len, byte_t instr, bit sum_ok,
	                                     bit cut, int tick_pct);
		byte_t sum;
		byte_t pb;
		int    body;
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		push_byte(id);
		push_byte(len);
		if (len < MIN_LENGTH)
			return;
		// body is instruction, len-2 parameters and the checksum: len bytes
		body = cut ? $urandom_range(0, int'(len) - 1) : int'(len);
		sum  = id + len + instr;
		for (int i = 0; i < body; i++) begin
			maybe_tick(tick_pct);
			if (i == 0) begin
				pb = instr;
			end else if (i == int'(len) - 1) begin
				pb = sum_ok ? ~sum : (~sum ^ byte_t'($urandom_range(1, 255)));
			end else begin
				pb  = byte_t'($urandom());
				sum = sum + pb;
			end
			push_byte(pb);
		end
	endfunction

	// mostly well-formed frames with random content, some noise and broken ones
	function automatic void fill_random(int target, int tick_pct);
		int    base;
		int    r;
		byte_t id;
		byte_t len;
		base = rx_stream.size();
		while (rx_stream.size() - base < target) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 4))
					push_byte(($urandom_range(2) == 0) ? HEADER_BYTE : byte_t'($urandom()));
			end
			r = $urandom_range(99);
			if (r < 45)
				id = own_id;
			else if (r < 75)
				id = BROADCAST_ID;
			else if (r < 90)
				id = byte_t'($urandom());
			else
				id = HEADER_BYTE;
			r = $urandom_range(99);
			if (r < 8)
				len = byte_t'($urandom_range(1));
			else if (r < 85)
				len = byte_t'($urandom_range(2, 8));
			else if (r < 97)
				len = byte_t'($urandom_range(9, 40));
			else
				len = byte_t'($urandom_range(41, 80));
			queue_packet(id, len, byte_t'($urandom()), $urandom_range(4) != 0,
			             $urandom_range(19) == 0, tick_pct);
		end
	endfunction

	// ---------------------------------------------------------------------
	// sequencing
	// ---------------------------------------------------------------------

	// everything sent, every result back, then a settle wait for byte-only work
	task automatic wait_idle();
		do
			@(negedge clk);
		while (rx_stream.size() != 0 || item_ch.valid || due_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[CFG_DATA_W-1:0];
		if (idx == REG_DEVICE_ID)
			own_id = val[7:0];
		else
			tick_limit = val[15:0];
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// sender holds off until the block is drained, then new settings and traffic
	task automatic run_phase(int unsigned id, int unsigned limit, bit src, bit sink,
	                         int tick_pct);
		wait_idle();
		write_reg(REG_DEVICE_ID, id);
		write_reg(REG_TIMEOUT, limit);
		src_idle  = src;
		sink_idle = sink;
		@(negedge clk);
		fill_random(PHASE_ITEMS, tick_pct);
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_DEVICE_ID;
		wr_data           = '0;
		item_ch.valid     = 1'b0;
		item_ch.operation = OP_BYTE;
		item_ch.rx_byte   = '0;
		result_ch.ready   = 1'b0;
		fail_count        = 0;
		src_idle          = 1'b1;
		sink_idle         = 1'b1;
		send_hold         = 0;
		take_hold         = 0;
		own_id            = DEVICE_ID_RESET;
		tick_limit        = TIMEOUT_RESET;
		fr_phase          = FR_HUNT;
		saw_ff            = 1'b0;
		pk_id             = '0;
		pk_len            = '0;
		pk_instr          = '0;
		pk_sum            = '0;
		pk_count          = '0;
		pk_ticks          = '0;

		// directed frames at reset settings (own id 1)
		// tick while hunting and while waiting for the id: both ignored;
		// instruction 0xff, one parameter 0x00, good checksum
		rx_stream.push_back('{OP_TICK, 8'hFF});
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		rx_stream.push_back('{OP_TICK, 8'h00});
		push_byte(8'h01);
		push_byte(8'h03);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(~(8'h01 + 8'h03 + 8'hFF + 8'h00));
		// broadcast, no parameters, wrong checksum
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		push_byte(BROADCAST_ID);
		push_byte(MIN_LENGTH);
		push_byte(8'h55);
		push_byte(~(BROADCAST_ID + MIN_LENGTH + 8'h55) ^ 8'h01);
		// foreign id, dropped without a result
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		push_byte(8'h07);
		// a third header byte is taken as the id and dropped
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		// zero length: bad length report right after the length byte
		push_byte(HEADER_BYTE);
		push_byte(HEADER_BYTE);
		push_byte(8'h01);
		push_byte(8'h00);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// lowest id, every tick after the length byte times out
		run_phase(0, 1, 1'b1, 1'b1, 12);
		// highest id and longest timeout, no idling on either side,
		// plus one frame of the largest length
		run_phase(253, 65535, 1'b0, 1'b0, 10);
		queue_packet(BROADCAST_ID, 8'd255, byte_t'($urandom()), 1'b1, 1'b0, 0);
		// short timeouts hit in the middle of frames
		run_phase($urandom_range(0, 253), $urandom_range(2, 12), 1'b1, 1'b1, 15);
		// medium timeouts, sender gaps only
		run_phase($urandom_range(0, 253), $urandom_range(13, 400), 1'b1, 1'b0, 8);

		wait_idle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard, well above the slowest legal run
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
